// File: hw/rtl/tdws_pkg.sv
// ----------------------------------------------------------------------------
// tdws_pkg
// Shared types, constants and helpers of the task due-window scheduler.
// ----------------------------------------------------------------------------
package tdws_pkg;

  localparam int MAX_TASKS_DEF = 64;

  localparam int TIME_W = 40;   // time fields
  localparam int WS_W   = 42;   // signed window start
  localparam int DUE_W  = 50;   // signed due time incl. products
  localparam int PER_W  = 31;   // interval / repeat period
  localparam int CNT_W  = 16;   // fire count, repeat limit
  localparam int PRD_W  = CNT_W + PER_W;
  localparam int DVD_W  = 41;   // divider dividend
  localparam int CFG_W  = 17;

  localparam int IN_DATA_W  = 176;
  localparam int IN_USER_W  = 2;
  localparam int OUT_DATA_W = 16;

  localparam logic [3:0] TRIG_INTERVAL = 4'b0001;
  localparam logic [3:0] TRIG_LIMITED  = 4'b0010;
  localparam logic [3:0] TRIG_STARTUP  = 4'b1000;

  localparam logic [CNT_W-1:0] CNT_MAX = '1;

  typedef enum logic [1:0] {
    CMD_EVAL = 2'd0,
    CMD_FIRE = 2'd1,
    CMD_RUN  = 2'd2,
    CMD_RSVD = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    RSN_NONE    = 2'd0,
    RSN_STARTUP = 2'd1,
    RSN_INTERVAL = 2'd2,
    RSN_LIMITED = 2'd3
  } reason_e;

  typedef enum logic [0:0] {
    CFG_POLL  = 1'b0,
    CFG_GRACE = 1'b1
  } cfg_idx_e;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_INT,
    ST_LIM,
    ST_LDUE,
    ST_DIV,
    ST_CDUE,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic [TIME_W-1:0] last_check;
    logic [TIME_W-1:0] last_fire;
    logic [CNT_W-1:0]  fire_count;
    logic              startup_done;
  } entry_t;

  function automatic logic in_win(logic signed [DUE_W-1:0] due,
                                  logic signed [DUE_W-1:0] ws,
                                  logic signed [DUE_W-1:0] now);
    return (due > ws) && (due <= now);
  endfunction

endpackage

// File: hw/rtl/tdws_div.sv
// ----------------------------------------------------------------------------
// tdws_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module tdws_div (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               start_i,
  input  logic [tdws_pkg::DVD_W-1:0]         dividend_i,
  input  logic [tdws_pkg::PER_W-1:0]         divisor_i,
  output logic                               done_o,
  output logic [tdws_pkg::DVD_W-1:0]         quot_o,
  output logic [tdws_pkg::PER_W-1:0]         rem_o
);

  localparam int IW = $clog2(tdws_pkg::DVD_W);

  logic                        busy_q;
  logic                        done_q;
  logic [IW-1:0]               cnt_q;
  logic [tdws_pkg::DVD_W-1:0]  dvd_q;
  logic [tdws_pkg::PER_W-1:0]  rem_q;
  logic [tdws_pkg::PER_W-1:0]  dvs_q;
  logic [tdws_pkg::PER_W:0]    trial;
  logic                        fits;

  assign trial = {rem_q, dvd_q[tdws_pkg::DVD_W-1]};
  assign fits  = trial >= {1'b0, dvs_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        if (cnt_q == IW'(tdws_pkg::DVD_W - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
        cnt_q <= cnt_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      dvd_q <= dividend_i;
      dvs_q <= divisor_i;
      rem_q <= '0;
    end else if (busy_q) begin
      rem_q <= fits ? tdws_pkg::PER_W'(trial - {1'b0, dvs_q})
                    : tdws_pkg::PER_W'(trial);
      dvd_q <= {dvd_q[tdws_pkg::DVD_W-2:0], fits};
    end
  end

  assign done_o = done_q;
  assign quot_o = dvd_q;
  assign rem_o  = rem_q;

endmodule

// File: hw/rtl/task_due_window_scheduler.sv
// ----------------------------------------------------------------------------
// task_due_window_scheduler
// Per-task due check with interval catch-up and limited repeats.
// ----------------------------------------------------------------------------
// Usage:
//  - Commands arrive on the s_axis channel: tuser carries the command (evaluate,
//    mark fired, mark observed running), tdata the task index, time and settings.
//  - One result per command leaves on m_axis: task index, due flag, reason.
//  - Configuration (poll period, grace time) is written on the cfg channel, always
//    ready. The user must write it only while no command is in flight; the block does not enforce this.
//  - One command at a time: mark commands and early decisions pass through the
//    READ and DONE states, and the block takes the next command back in IDLE.
//    An evaluate that needs catch-up runs the shared divider (41 steps) once
//    or twice before its result. The table memory read is registered and the
//    divider is bit-serial.
//  - Task state sits in one synchronous RAM of MAX_TASKS words; each command
//    reads its entry and writes any update back before the next one is
//    taken, so no forwarding is needed.
//  - After reset the RAM is cleared one word per cycle, all MAX_TASKS words, with
//    s_axis_tready low; cfg writes are taken during that sweep.
//  - A result is held in the output register while m_axis_tready is low; the
//    block then waits before writing back and taking the next command.
// ----------------------------------------------------------------------------
module task_due_window_scheduler #(
  parameter int MAX_TASKS = tdws_pkg::MAX_TASKS_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // tdata: task_index[5:0], now_time[45:6], task_enabled[46],
  // trigger_set[50:47], interval_length[81:51], repeat_limit[97:82],
  // repeat_period[128:98], start_time[168:129], start_valid[169],
  // consume_count[170], zero pad
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  input  logic [tdws_pkg::IN_DATA_W-1:0]    s_axis_tdata,
  // tuser: cmd[1:0]
  input  logic [tdws_pkg::IN_USER_W-1:0]    s_axis_tuser,
  // tdata: result_task[5:0], is_due[6], due_reason[8:7], zero pad
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  output logic [tdws_pkg::OUT_DATA_W-1:0]   m_axis_tdata,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic                              cfg_addr_i,
  input  logic [tdws_pkg::CFG_W-1:0]        cfg_data_i
);

  localparam int AW = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
  localparam int TW = tdws_pkg::TIME_W;
  localparam int DW = tdws_pkg::DUE_W;

  // config
  logic [tdws_pkg::CFG_W-1:0] poll_q, grace_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      poll_q  <= tdws_pkg::CFG_W'(1);
      grace_q <= '0;
    end else if (cfg_valid_i) begin
      unique case (tdws_pkg::cfg_idx_e'(cfg_addr_i))
        tdws_pkg::CFG_POLL:  poll_q  <= cfg_data_i;
        tdws_pkg::CFG_GRACE: grace_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // command capture
  tdws_pkg::state_e state_q, state_d;
  logic in_xfer, out_load;

  assign s_axis_tready = (state_q == tdws_pkg::ST_IDLE);
  assign in_xfer       = s_axis_tvalid && s_axis_tready;

  tdws_pkg::cmd_e              cmd_q;
  logic [5:0]                  tix_q;
  logic [TW-1:0]               now_q, start_q;
  logic                        en_q, sv_q, cons_q;
  logic [3:0]                  trig_q;
  logic [tdws_pkg::PER_W-1:0]  ilen_q, rper_q;
  logic [tdws_pkg::CNT_W-1:0]  rlim_q;

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      cmd_q   <= tdws_pkg::cmd_e'(s_axis_tuser[1:0]);
      tix_q   <= s_axis_tdata[5:0];
      now_q   <= s_axis_tdata[45:6];
      en_q    <= s_axis_tdata[46];
      trig_q  <= s_axis_tdata[50:47];
      ilen_q  <= s_axis_tdata[81:51];
      rlim_q  <= s_axis_tdata[97:82];
      rper_q  <= s_axis_tdata[128:98];
      start_q <= s_axis_tdata[168:129];
      sv_q    <= s_axis_tdata[169];
      cons_q  <= s_axis_tdata[170];
    end
  end

  // task table
  tdws_pkg::entry_t mem_q [MAX_TASKS];
  tdws_pkg::entry_t rd_q, wdata;
  logic [AW-1:0]    clr_q, waddr;
  logic             we;

  always_ff @(posedge clk_i) begin
    if (we) mem_q[waddr] <= wdata;
    if (in_xfer) rd_q <= mem_q[AW'(s_axis_tdata[5:0])];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) clr_q <= '0;
    else if (state_q == tdws_pkg::ST_CLEAR) clr_q <= clr_q + 1'b1;
  end

  // datapath
  logic signed [tdws_pkg::WS_W-1:0] lc_w, gs_w, ws_d, ws_q, now42;
  logic signed [DW-1:0] ws50, now50, due_int, due_l, due_c;
  logic [tdws_pkg::PRD_W-1:0] prod_q;
  logic [tdws_pkg::CNT_W-1:0] cnt_mux;
  logic [tdws_pkg::WS_W-1:0]  cnt_sum;
  logic int_on, lim_on, in_range, we_q, mode_lim_q;
  tdws_pkg::reason_e reason_q, reason_d;

  logic                        div_start, div_done;
  logic [tdws_pkg::DVD_W-1:0]  div_dvd, div_quot;
  logic [tdws_pkg::PER_W-1:0]  div_dvs, div_rem;

  assign in_range = 32'(tix_q) < 32'(MAX_TASKS);
  assign now42    = {2'b00, now_q};
  assign lc_w     = (rd_q.last_check == '0) ? now42 - {25'b0, poll_q}
                                            : {2'b00, rd_q.last_check};
  assign gs_w     = now42 - {25'b0, grace_q};
  assign ws_d     = ((grace_q != '0) && (lc_w < gs_w)) ? gs_w : lc_w;

  assign ws50     = {{(DW - tdws_pkg::WS_W){ws_q[tdws_pkg::WS_W-1]}}, ws_q};
  assign now50    = {10'b0, now_q};
  assign due_int  = {10'b0, rd_q.last_fire} + {19'b0, ilen_q};
  assign due_l    = {10'b0, start_q} + {3'b0, prod_q};
  // catch-up step lands at ws - rem + ilen
  assign due_c    = ws50 - {19'b0, div_rem} + {19'b0, ilen_q};

  assign int_on = ((trig_q & tdws_pkg::TRIG_INTERVAL) != '0) && (ilen_q != '0);
  assign lim_on = ((trig_q & tdws_pkg::TRIG_LIMITED) != '0) && (rlim_q != '0)
                  && (rd_q.fire_count < rlim_q) && (rper_q != '0) && sv_q;

  assign cnt_sum = {26'b0, rd_q.fire_count} + {1'b0, div_quot} + 1'b1;
  assign cnt_mux = (cnt_sum > {26'b0, rlim_q}) ? rlim_q
                                               : tdws_pkg::CNT_W'(cnt_sum);

  tdws_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dvd),
    .divisor_i  (div_dvs),
    .done_o     (div_done),
    .quot_o     (div_quot),
    .rem_o      (div_rem)
  );

  // control
  always_comb begin
    state_d   = state_q;
    reason_d  = reason_q;
    div_start = 1'b0;
    div_dvd   = tdws_pkg::DVD_W'(ws50 - due_int);
    div_dvs   = ilen_q;
    out_load  = 1'b0;
    unique case (state_q)
      tdws_pkg::ST_CLEAR: begin
        if (clr_q == AW'(MAX_TASKS - 1)) state_d = tdws_pkg::ST_IDLE;
      end
      tdws_pkg::ST_IDLE: begin
        reason_d = tdws_pkg::RSN_NONE;
        if (in_xfer) state_d = tdws_pkg::ST_READ;
      end
      tdws_pkg::ST_READ: begin
        if (!in_range || (cmd_q != tdws_pkg::CMD_EVAL) || !en_q) begin
          state_d = tdws_pkg::ST_DONE;
        end else if (((trig_q & tdws_pkg::TRIG_STARTUP) != '0)
                     && !rd_q.startup_done) begin
          reason_d = tdws_pkg::RSN_STARTUP;
          state_d  = tdws_pkg::ST_DONE;
        end else begin
          state_d = tdws_pkg::ST_INT;
        end
      end
      tdws_pkg::ST_INT: begin
        state_d = tdws_pkg::ST_LIM;
        if (int_on) begin
          if (rd_q.last_fire == '0) begin
            if (now50 > ws50) begin
              reason_d = tdws_pkg::RSN_INTERVAL;
              state_d  = tdws_pkg::ST_DONE;
            end
          end else if (due_int <= ws50) begin
            div_start = 1'b1;
            state_d   = tdws_pkg::ST_DIV;
          end else if (tdws_pkg::in_win(due_int, ws50, now50)) begin
            reason_d = tdws_pkg::RSN_INTERVAL;
            state_d  = tdws_pkg::ST_DONE;
          end
        end
      end
      tdws_pkg::ST_LIM: begin
        state_d = lim_on ? tdws_pkg::ST_LDUE : tdws_pkg::ST_DONE;
      end
      tdws_pkg::ST_LDUE: begin
        div_dvd = tdws_pkg::DVD_W'(ws50 - due_l);
        div_dvs = rper_q;
        if (due_l <= ws50) begin
          div_start = 1'b1;
          state_d   = tdws_pkg::ST_DIV;
        end else begin
          if (tdws_pkg::in_win(due_l, ws50, now50)) reason_d = tdws_pkg::RSN_LIMITED;
          state_d = tdws_pkg::ST_DONE;
        end
      end
      tdws_pkg::ST_DIV: begin
        if (div_done) begin
          if (mode_lim_q) begin
            state_d = tdws_pkg::ST_CDUE;
          end else if (tdws_pkg::in_win(due_c, ws50, now50)) begin
            reason_d = tdws_pkg::RSN_INTERVAL;
            state_d  = tdws_pkg::ST_DONE;
          end else begin
            state_d = tdws_pkg::ST_LIM;
          end
        end
      end
      tdws_pkg::ST_CDUE: begin
        if (tdws_pkg::in_win(due_l, ws50, now50)) reason_d = tdws_pkg::RSN_LIMITED;
        state_d = tdws_pkg::ST_DONE;
      end
      tdws_pkg::ST_DONE: begin
        if (!m_axis_tvalid || m_axis_tready) begin
          out_load = 1'b1;
          state_d  = tdws_pkg::ST_IDLE;
        end
      end
      default: state_d = tdws_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= tdws_pkg::ST_CLEAR;
      reason_q <= tdws_pkg::RSN_NONE;
    end else begin
      state_q  <= state_d;
      reason_q <= reason_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == tdws_pkg::ST_READ) begin
      ws_q       <= ws_d;
      we_q       <= in_range && ((cmd_q == tdws_pkg::CMD_FIRE)
                    || (cmd_q == tdws_pkg::CMD_RUN)
                    || ((cmd_q == tdws_pkg::CMD_EVAL) && en_q));
      mode_lim_q <= 1'b0;
    end
    if (state_q == tdws_pkg::ST_LIM) begin
      prod_q     <= rd_q.fire_count * rper_q;
      mode_lim_q <= 1'b1;
    end
    if ((state_q == tdws_pkg::ST_DIV) && div_done && mode_lim_q)
      prod_q <= cnt_mux * rper_q;
  end

  // write back
  always_comb begin
    wdata = rd_q;
    waddr = AW'(tix_q);
    we    = 1'b0;
    if (state_q == tdws_pkg::ST_CLEAR) begin
      wdata = '0;
      waddr = clr_q;
      we    = 1'b1;
    end else if (out_load && we_q) begin
      we = 1'b1;
      if (cmd_q == tdws_pkg::CMD_EVAL) begin
        wdata.last_check = now_q;
      end else begin
        wdata.last_fire    = now_q;
        wdata.startup_done = 1'b1;
        if (((cmd_q == tdws_pkg::CMD_FIRE) || cons_q)
            && (rd_q.fire_count != tdws_pkg::CNT_MAX))
          wdata.fire_count = rd_q.fire_count + 1'b1;
      end
    end
  end

  // output register
  logic                      m_valid_q;
  logic [5:0]                o_task_q;
  tdws_pkg::reason_e         o_reason_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) m_valid_q <= 1'b0;
    else if (out_load) m_valid_q <= 1'b1;
    else if (m_axis_tready) m_valid_q <= 1'b0;
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      o_task_q   <= tix_q;
      o_reason_q <= reason_q;
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = {7'b0, o_reason_q, (o_reason_q != tdws_pkg::RSN_NONE), o_task_q};

endmodule

// File: hw/rtl/tdws_chk.sv
// ----------------------------------------------------------------------------
// tdws_chk
// Port-level checks of the task due-window scheduler.
// ----------------------------------------------------------------------------
module tdws_chk (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            s_axis_tvalid,
  input logic                            s_axis_tready,
  input logic                            m_axis_tvalid,
  input logic                            m_axis_tready,
  input logic [tdws_pkg::OUT_DATA_W-1:0] m_axis_tdata
);

  // held result stays put
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed while stalled");

  // due flag matches reason
  a_due: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[6] == (m_axis_tdata[8:7] != 2'd0)))
    else $error("is_due disagrees with due_reason");

  // one command in flight
  a_one: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("second command taken while busy");

  // no result in the cycle right after a transfer
  a_lat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !$rose(m_axis_tvalid))
    else $error("result too early");

endmodule

bind task_due_window_scheduler tdws_chk u_tdws_chk (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
